### rtl/cht_pkg.sv
// package for the chained hash table unit
// shared constants, operation and status codes; no dependencies
package cht_pkg;
  localparam int unsigned BUCKETS_DEF    = 1024;
  localparam int unsigned NODES_DEF      = 1024;
  localparam int unsigned VALUE_BITS_DEF = 32;
  localparam int unsigned KEY_W          = 64;
  localparam int unsigned IN_VALUE_W     = 32;
  localparam int unsigned OUT_VALUE_W    = 32;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_REMOVE = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_POOL_FULL = 2'd2
  } status_t;
endpackage

### rtl/cht_req_if.sv
// request channel interface of the chained hash table unit
// depends on cht_pkg
interface cht_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic signed [cht_pkg::KEY_W-1:0] key;
  logic [cht_pkg::IN_VALUE_W-1:0]   value;
  modport source (output valid, mode, key, value, input ready);
  modport sink   (input valid, mode, key, value, output ready);
endinterface

### rtl/cht_rsp_if.sv
// response channel interface of the chained hash table unit
// depends on cht_pkg
interface cht_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [cht_pkg::OUT_VALUE_W-1:0] found_value;
  modport source (output valid, status, found_value, input ready);
  modport sink   (input valid, status, found_value, output ready);
endinterface

### rtl/chained_hash_table_unit.sv
// chained hash table unit: bucket heads, node pool, free stack, chain walker
// depends on cht_pkg, cht_req_if, cht_rsp_if
//
// channel | dir | payload
// req     | in  | mode, key, value
// rsp     | out | status, found_value
//
// a clearing pass after reset sets every bucket head to null; no item is taken
// meanwhile. one item at a time: lookup and remove read the bucket head, then
// walk the chain node by node up to the match or the end, and a remove hit
// unlinks the node; insert takes a node and links it at the head of the chain.
// each memory has a single read port (head memory, then node memory). the
// response is held in an output register until taken; the next item is accepted
// once it is gone.
module chained_hash_table_unit #(
  parameter int unsigned BUCKETS    = cht_pkg::BUCKETS_DEF,
  parameter int unsigned NODES      = cht_pkg::NODES_DEF,
  parameter int unsigned VALUE_BITS = cht_pkg::VALUE_BITS_DEF
) (
  input logic clk,
  input logic rst,
  cht_req_if.sink   req,
  cht_rsp_if.source rsp
);
  import cht_pkg::*;

  localparam int unsigned BW  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int unsigned NW  = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int unsigned PW  = NW + 1;
  localparam int unsigned VW  = (VALUE_BITS < OUT_VALUE_W) ? VALUE_BITS : OUT_VALUE_W;
  localparam logic [PW-1:0] NULLP = PW'(NODES);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_HEAD, S_HEAD_WAIT, S_NODE, S_NODE_WAIT, S_UNLINK,
    S_ALLOC, S_ALLOC_WAIT, S_WRITE, S_RESP
  } state_t;

  // memories
  logic [PW-1:0]          heads     [BUCKETS];
  logic [KEY_W-1:0]       node_keys [NODES];
  logic [VW-1:0]          node_vals [NODES];
  logic [PW-1:0]          node_links[NODES];
  logic [NW-1:0]          free_stack[NODES];

  state_t            state;
  logic [1:0]        op;
  logic [KEY_W-1:0]  key_r;
  logic [VW-1:0]     val_r;
  logic [BW-1:0]     bkt;
  logic [PW-1:0]     cur, prev, head_q, link_q;
  logic [KEY_W-1:0]  nkey_q;
  logic [VW-1:0]     nval_q;
  logic [NW-1:0]     fs_q;
  logic [PW-1:0]     free_top, never_used;
  logic [NW:0]       steps;
  logic [BW:0]       clr_cnt;
  logic [NW-1:0]     alloc;
  logic [1:0]        st_r;
  logic [OUT_VALUE_W-1:0] fv_r;

  assign req.ready       = (state == S_IDLE);
  assign rsp.valid       = (state == S_RESP);
  assign rsp.status      = st_r;
  assign rsp.found_value = fv_r;

  // head memory: one read, one write port
  always_ff @(posedge clk) begin
    head_q <= heads[bkt];
    if (state == S_CLEAR) begin
      heads[clr_cnt[BW-1:0]] <= NULLP;
    end else if (state == S_WRITE) begin
      heads[bkt] <= PW'(alloc);
    end else if (state == S_UNLINK && prev == NULLP) begin
      heads[bkt] <= link_q;
    end
  end

  // node memory: read at cur, written on insert and unlink
  always_ff @(posedge clk) begin
    nkey_q <= node_keys[cur[NW-1:0]];
    nval_q <= node_vals[cur[NW-1:0]];
    link_q <= node_links[cur[NW-1:0]];
    if (state == S_WRITE) begin
      node_keys[alloc]  <= key_r;
      node_vals[alloc]  <= val_r;
      node_links[alloc] <= head_q;
    end else if (state == S_UNLINK && prev != NULLP) begin
      node_links[prev[NW-1:0]] <= link_q;
    end
  end

  // free stack memory
  always_ff @(posedge clk) begin
    fs_q <= free_stack[NW'(free_top - PW'(1))];
    if (state == S_UNLINK && free_top < NULLP) begin
      free_stack[free_top[NW-1:0]] <= cur[NW-1:0];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_cnt    <= '0;
      free_top   <= '0;
      never_used <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == (BW+1)'(BUCKETS - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (req.valid) begin
            op    <= req.mode;
            key_r <= req.key;
            val_r <= req.value[VW-1:0];
            bkt   <= req.key[BW-1:0];
            prev  <= NULLP;
            steps <= '0;
            fv_r  <= '0;
            case (op_t'(req.mode))
              OP_INSERT: state <= S_ALLOC;
              OP_LOOKUP, OP_REMOVE: state <= S_HEAD;
              default: begin
                st_r  <= ST_NOT_FOUND;
                state <= S_RESP;
              end
            endcase
          end
        end
        // bucket head read issued by bkt; wait for data
        S_HEAD: state <= S_HEAD_WAIT;
        S_HEAD_WAIT: begin
          cur   <= head_q;
          state <= S_NODE;
        end
        S_NODE: begin
          if (cur >= NULLP || steps >= (NW+1)'(NODES)) begin
            st_r  <= ST_NOT_FOUND;
            state <= S_RESP;
          end else begin
            state <= S_NODE_WAIT;
          end
        end
        // compare the key of the node just read
        S_NODE_WAIT: begin
          if (nkey_q == key_r) begin
            st_r <= ST_DONE;
            fv_r <= OUT_VALUE_W'(nval_q);
            state <= (op == OP_REMOVE) ? S_UNLINK : S_RESP;
          end else begin
            prev  <= cur;
            cur   <= link_q;
            steps <= steps + 1'b1;
            state <= S_NODE;
          end
        end
        S_UNLINK: begin
          if (free_top < NULLP) free_top <= free_top + 1'b1;
          state <= S_RESP;
        end
        // pick a node: free stack first, then never used ones
        S_ALLOC: begin
          if (free_top == '0 && never_used >= NULLP) begin
            st_r  <= ST_POOL_FULL;
            state <= S_RESP;
          end else begin
            state <= S_ALLOC_WAIT;
          end
        end
        S_ALLOC_WAIT: begin
          if (free_top != '0) begin
            alloc    <= fs_q;
            free_top <= free_top - 1'b1;
          end else begin
            alloc      <= never_used[NW-1:0];
            never_used <= never_used + 1'b1;
          end
          state <= S_WRITE;
        end
        S_WRITE: begin
          st_r  <= ST_DONE;
          state <= S_RESP;
        end
        S_RESP: if (rsp.ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

### verif/cht_scoreboard.sv
// scoreboard for the chained hash table unit: mirrors the table and checks responses
// depends on cht_pkg, cht_req_if, cht_rsp_if
`timescale 1ns / 100ps
module cht_scoreboard
  import cht_pkg::*;
#(
  parameter int unsigned BUCKETS = BUCKETS_DEF,
  parameter int unsigned NODES   = NODES_DEF
) (
  input  logic clk,
  input  logic rst,
  cht_req_if   req,
  cht_rsp_if   rsp,
  output int   errors,
  output int   pending
);
  localparam int unsigned NW = $clog2(NODES) + 1;
  localparam logic [NW-1:0] NIL = NW'(NODES);

  typedef struct packed {
    status_t     status;
    logic [31:0] found_value;
  } rsp_item_t;

  // mirrored table state
  logic [NW-1:0]       heads [BUCKETS];
  logic signed [63:0]  node_key [NODES];
  logic [31:0]         node_val [NODES];
  logic [NW-1:0]       node_next [NODES];
  logic [NW-1:0]       free_stack [NODES];
  int unsigned         free_cnt;
  int unsigned         fresh_next;
  rsp_item_t           expected_rsps[$];

  assign pending = expected_rsps.size();

  // apply one operation to the mirror and return its response
  function automatic rsp_item_t apply_op(logic [1:0] mode, logic signed [63:0] key,
                                         logic [31:0] value);
    rsp_item_t r;
    int unsigned b, n;
    logic [NW-1:0] cur, prv;
    r.status = ST_NOT_FOUND;
    r.found_value = '0;
    b = key & (BUCKETS - 1);
    if (mode == OP_INSERT) begin
      if (free_cnt > 0) begin
        free_cnt--;
        n = free_stack[free_cnt];
      end else if (fresh_next < NODES) begin
        n = fresh_next++;
      end else begin
        r.status = ST_POOL_FULL;
        return r;
      end
      node_key[n] = key;
      node_val[n] = value;
      node_next[n] = heads[b];
      heads[b] = NW'(n);
      r.status = ST_DONE;
      return r;
    end
    if (mode == OP_NONE) return r;
    // walk the chain for the first match
    cur = heads[b];
    prv = NIL;
    for (int s = 0; cur != NIL && s < NODES; s++) begin
      if (node_key[cur] == key) begin
        r.status = ST_DONE;
        r.found_value = node_val[cur];
        if (mode == OP_REMOVE) begin
          if (prv != NIL) node_next[prv] = node_next[cur];
          else heads[b] = node_next[cur];
          if (free_cnt < NODES) free_stack[free_cnt++] = cur;
        end
        return r;
      end
      prv = cur;
      cur = node_next[cur];
    end
    return r;
  endfunction

  // clear the mirror in reset; predict on accepted requests, compare on accepted responses
  always @(posedge clk) begin
    rsp_item_t e;
    if (rst) begin
      errors = 0;
      for (int i = 0; i < BUCKETS; i++) heads[i] = NIL;
      free_cnt = 0;
      fresh_next = 0;
      expected_rsps.delete();
    end else begin
      if (req.valid && req.ready)
        expected_rsps.push_back(apply_op(req.mode, req.key, req.value));
      if (rsp.valid && rsp.ready) begin
        if (expected_rsps.size() == 0) begin
          $error("response with no request outstanding");
          errors++;
        end else begin
          e = expected_rsps.pop_front();
          if (rsp.status !== e.status) begin
            $error("status expected %0d actual %0d", e.status, rsp.status);
            errors++;
          end
          if (rsp.found_value !== e.found_value) begin
            $error("found_value expected %h actual %h", e.found_value, rsp.found_value);
            errors++;
          end
        end
      end
    end
  end
endmodule

### verif/tb_chained_hash_table_unit.sv
// top of the chained hash table testbench: clock, reset, stimulus and verdict
// depends on cht_pkg, cht_req_if, cht_rsp_if, cht_scoreboard, chained_hash_table_unit
`timescale 1ns / 100ps
module tb_chained_hash_table_unit;
  import cht_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   errors, pending;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  int   hold_cycles = 0;
  logic hold_go = 1'b0;
  logic hold_used = 1'b0;
  logic signed [63:0] key_pool [48];

  cht_req_if req ();
  cht_rsp_if rsp ();

  chained_hash_table_unit dut (.clk(clk), .rst(rst), .req(req), .rsp(rsp));
  cht_scoreboard sb (.clk(clk), .rst(rst), .req(req), .rsp(rsp),
                     .errors(errors), .pending(pending));

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #4000000;
    $display("Test completed with failures");
    $finish;
  end

  // receiver: random backpressure plus one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else if (hold_go && !hold_used) begin
      hold_used   <= 1'b1;
      hold_cycles <= 300;
      rsp.ready   <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // offer one item and wait until it is taken
  task automatic send_item(op_t op, logic signed [63:0] key, logic [31:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid <= 1'b1;
    req.mode  <= op;
    req.key   <= key;
    req.value <= value;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
  endtask

  function automatic op_t pick_op();
    int r;
    r = $urandom_range(99);
    if (r < 40) return OP_INSERT;
    if (r < 70) return OP_LOOKUP;
    if (r < 95) return OP_REMOVE;
    return OP_NONE;
  endfunction

  task automatic random_items(int count);
    for (int i = 0; i < count; i++)
      send_item(pick_op(), key_pool[$urandom_range(47)], $urandom);
  endtask

  localparam logic signed [63:0] K_MAX = 64'sh7fff_ffff_ffff_ffff;
  localparam logic signed [63:0] K_MIN = 64'sh8000_0000_0000_0000;
  localparam logic signed [63:0] K_A   = 64'sd5;
  localparam logic signed [63:0] K_B   = 64'sd5 | (64'sd1 << 10);
  localparam logic signed [63:0] K_C   = K_MIN | 64'sd5;

  initial begin
    req.valid = 1'b0;
    req.mode  = OP_NONE;
    req.key   = '0;
    req.value = '0;
    // key pool: a third share a few buckets to build chains
    for (int i = 0; i < 48; i++) begin
      key_pool[i] = {$urandom, $urandom};
      if (i % 3 == 0) key_pool[i][9:0] = 10'(i % 4);
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: empty miss, chain order, shadowing, extremes, unused mode
    send_idle_pct = 20;
    recv_idle_pct = 51;
    send_item(OP_LOOKUP, K_A, 32'h0);
    send_item(OP_INSERT, K_A, 32'hffff_ffff);
    send_item(OP_INSERT, K_B, 32'h0);
    send_item(OP_INSERT, K_C, 32'h1);
    send_item(OP_INSERT, K_A, 32'h1234_5678);
    send_item(OP_LOOKUP, K_A, 32'h0);
    send_item(OP_LOOKUP, K_C, 32'h0);
    send_item(OP_REMOVE, K_A, 32'h0);
    send_item(OP_LOOKUP, K_A, 32'h0);
    send_item(OP_REMOVE, K_B, 32'h0);
    send_item(OP_REMOVE, K_A, 32'h0);
    send_item(OP_REMOVE, K_A, 32'h0);
    send_item(OP_LOOKUP, K_C, 32'h0);
    send_item(OP_INSERT, -64'sd1, 32'haaaa_5555);
    send_item(OP_INSERT, K_MAX, 32'h5555_aaaa);
    send_item(OP_INSERT, K_MIN, 32'h8000_0001);
    send_item(OP_INSERT, 64'sd0, 32'h7fff_fffe);
    send_item(OP_LOOKUP, K_MIN, 32'h0);
    send_item(OP_REMOVE, 64'sd0, 32'h0);
    send_item(OP_LOOKUP, -64'sd1, 32'h0);
    send_item(OP_NONE, -64'sd1, 32'hffff_ffff);
    send_item(OP_REMOVE, K_MIN, 32'h0);
    send_item(OP_REMOVE, K_MAX, 32'h0);
    send_item(OP_LOOKUP, K_MAX, 32'h0);

    // random traffic over a small key pool
    random_items(350);
    send_idle_pct = 51;
    recv_idle_pct = 20;
    random_items(350);
    send_idle_pct = 0;
    recv_idle_pct = 0;

    // long receiver stall while the sender keeps offering
    hold_go <= 1'b1;
    random_items(20);

    // fill the pool past its size, then churn and refill
    for (int i = 0; i < 1040; i++) send_item(OP_INSERT, {$urandom, $urandom}, $urandom);
    random_items(40);
    for (int i = 0; i < 20; i++) send_item(OP_INSERT, key_pool[$urandom_range(47)], $urandom);
    req.valid <= 1'b0;

    @(posedge clk);
    wait (pending == 0);
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
